// ===== src/sbblur_pkg.sv =====
package sbblur_pkg;

  localparam int CHAN_W = 8;
  localparam int CFG_W  = 11;
  localparam int POS_W  = 10;

  // Configuration register indexes
  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // One pixel, chroma in the lowest bits
  typedef struct packed {
    logic [CHAN_W-1:0] border;
    logic [CHAN_W-1:0] luma;
    logic [CHAN_W-1:0] chroma;
  } pix_t;

  // One line-store entry: horizontal results of the two previous rows
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_ent_t;

  // Three-tap [1 2 1]/4 on both channels, OR of the border masks
  function automatic pix_t tap3(input pix_t a, input pix_t b, input pix_t c);
    logic [CHAN_W+1:0] ch;
    logic [CHAN_W+1:0] lu;
    pix_t              res;
    ch = {2'b00, a.chroma} + {1'b0, b.chroma, 1'b0} + {2'b00, c.chroma};
    lu = {2'b00, a.luma} + {1'b0, b.luma, 1'b0} + {2'b00, c.luma};
    res.chroma = ch[CHAN_W+1:2];
    res.luma   = lu[CHAN_W+1:2];
    res.border = a.border | b.border | c.border;
    return res;
  endfunction

  // Two-tap average used at edge columns and edge rows
  function automatic pix_t tap2(input pix_t a, input pix_t b);
    logic [CHAN_W:0] ch;
    logic [CHAN_W:0] lu;
    pix_t            res;
    ch = {1'b0, a.chroma} + {1'b0, b.chroma};
    lu = {1'b0, a.luma} + {1'b0, b.luma};
    res.chroma = ch[CHAN_W:1];
    res.luma   = lu[CHAN_W:1];
    res.border = a.border | b.border;
    return res;
  endfunction

endpackage

// ===== src/sbblur_line_mem.sv =====
module sbblur_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  sbblur_pkg::line_ent_t wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr_a,
  input  logic [AW-1:0]         raddr_b,
  output sbblur_pkg::line_ent_t rdata_a,
  output sbblur_pkg::line_ent_t rdata_b
);

  sbblur_pkg::line_ent_t mem [DEPTH];
  sbblur_pkg::line_ent_t rdata_a_r;
  sbblur_pkg::line_ent_t rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== src/separable_binomial_blur_3x3_unit.sv =====
// Separable 3x3 binomial blur over a raster-order pixel stream. Each pixel
// (chroma, luma, border mask) goes through a horizontal then a vertical
// [1 2 1]/4 filter; edge columns and rows use the two-tap average and the
// border result is the OR of the masks in the window. A result leaves as
// soon as its window is complete: the pixel at column x (x >= 1) releases
// column x-1 of the previous row, so row 0 and column 0 give no result on
// their own and the last pixel of a row also releases the last column; the
// last pixel of a row in the last row releases up to four results. A pixel
// past column 0 is held in the result stage until it has sent every result
// it releases, because the single output register sends one result per
// clock; in row 0, which releases nothing, it still steps through each
// column it closes. So pixels are taken one per clock inside a row other
// than the last; a pixel closing a row, or past column 0 of the last row,
// holds the input until its steps are done. A stalled output holds a stage
// that has results to send, and the input with it. A pixel is registered
// in the result stage, its results in the output register. The two line
// stores are one memory of MAX_WIDTH entries with two read ports and one
// write port; it needs no clearing after reset. frame_width and
// frame_height are clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT] and must
// only be written while the block is idle.
module separable_binomial_blur_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_addr,
  input  logic [sbblur_pkg::CFG_W-1:0] cfg_wdata,
  // pixel input
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,  // chroma_in, luma_in, border_in
  // result output
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata, // chroma_out, luma_out, border_out,
                                                  // out_col, out_row, 4'b0 pad
  output logic                         out_tlast  // last_of_run
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int SZW    = (sbblur_pkg::CFG_W > CW + 1) ? sbblur_pkg::CFG_W : CW + 1;
  localparam int SZH    = (sbblur_pkg::CFG_W > RW + 1) ? sbblur_pkg::CFG_W : RW + 1;
  localparam int COL_XW = (CW > sbblur_pkg::POS_W) ? CW : sbblur_pkg::POS_W;
  localparam int ROW_XW = (RW > sbblur_pkg::POS_W) ? RW : sbblur_pkg::POS_W;

  // configuration
  logic [sbblur_pkg::CFG_W-1:0] frame_width_r;
  logic [sbblur_pkg::CFG_W-1:0] frame_height_r;

  // input side state
  sbblur_pkg::pix_t left_r;
  sbblur_pkg::pix_t center_r;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;

  // result stage: one accepted pixel and its one or two vertical jobs
  logic             s1_valid_r;
  logic             s1_two_r;
  logic             s1_last_row_r;
  logic [RW-1:0]    s1_row_r;
  logic [CW-1:0]    s1_col_r;
  sbblur_pkg::pix_t s1_h1_r;
  sbblur_pkg::pix_t s1_h2_r;
  logic             js_r;
  logic             rs_r;

  // output register
  logic                         out_valid_r;
  sbblur_pkg::pix_t             out_pix_r;
  logic [sbblur_pkg::POS_W-1:0] out_col_r;
  logic [sbblur_pkg::POS_W-1:0] out_row_r;
  logic                         out_last_r;

  // combinational
  sbblur_pkg::pix_t      cur_pix;
  logic [SZW-1:0]        w_clamp;
  logic [SZW-1:0]        w_m1;
  logic [SZH-1:0]        h_clamp;
  logic [SZH-1:0]        h_m1;
  logic                  last_col;
  logic                  last_row;
  logic                  in_acc;
  logic                  load;
  sbblur_pkg::pix_t      h1;
  sbblur_pkg::pix_t      h2;
  sbblur_pkg::line_ent_t rd_a;
  sbblur_pkg::line_ent_t rd_b;
  sbblur_pkg::line_ent_t ent;
  sbblur_pkg::line_ent_t wr_ent;
  sbblur_pkg::pix_t      hsel;
  sbblur_pkg::pix_t      vres;
  logic [CW-1:0]         job_col;
  logic [RW-1:0]         res_row;
  logic [COL_XW-1:0]     col_x;
  logic [ROW_XW-1:0]     row_x;
  logic                  emit;
  logic                  job_end;
  logic                  last_step;
  logic                  out_free;
  logic                  adv;
  logic [CW-1:0]         rd_addr_a;

  assign cur_pix = sbblur_pkg::pix_t'(in_tdata);

  // clamp the frame size to the supported range
  always_comb begin
    if (frame_width_r < sbblur_pkg::CFG_W'(2)) begin
      w_clamp = SZW'(2);
    end else if (SZW'(frame_width_r) > SZW'(MAX_WIDTH)) begin
      w_clamp = SZW'(MAX_WIDTH);
    end else begin
      w_clamp = SZW'(frame_width_r);
    end
    if (frame_height_r < sbblur_pkg::CFG_W'(2)) begin
      h_clamp = SZH'(2);
    end else if (SZH'(frame_height_r) > SZH'(MAX_HEIGHT)) begin
      h_clamp = SZH'(MAX_HEIGHT);
    end else begin
      h_clamp = SZH'(frame_height_r);
    end
  end

  assign w_m1     = w_clamp - SZW'(1);
  assign h_m1     = h_clamp - SZH'(1);
  assign last_col = SZW'(col_r) >= w_m1;
  assign last_row = SZH'(row_r) >= h_m1;

  // horizontal pass on the incoming pixel
  assign h1 = (col_r == CW'(1)) ? sbblur_pkg::tap2(center_r, cur_pix)
                                : sbblur_pkg::tap3(left_r, center_r, cur_pix);
  assign h2 = sbblur_pkg::tap2(center_r, cur_pix);

  assign in_acc    = in_tvalid && in_tready;
  assign load      = in_acc && (col_r != '0);
  assign rd_addr_a = col_r - CW'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sbblur_pkg::FRAME_WIDTH_RST;
      frame_height_r <= sbblur_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbblur_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        sbblur_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
      endcase
    end
  end

  // advance the pixel window and the raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      center_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (in_acc) begin
      left_r   <= (col_r == '0) ? sbblur_pkg::pix_t'('0) : center_r;
      center_r <= cur_pix;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line store: column x-1 and column x read at accept
  sbblur_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .we      (adv && job_end),
    .waddr   (job_col),
    .wdata   (wr_ent),
    .re      (load),
    .raddr_a (rd_addr_a),
    .raddr_b (col_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // vertical pass for the current job and result
  always_comb begin
    ent       = js_r ? rd_b : rd_a;
    hsel      = js_r ? s1_h2_r : s1_h1_r;
    job_col   = s1_col_r + CW'(js_r);
    emit      = (s1_row_r != '0);
    job_end   = !emit || rs_r || !s1_last_row_r;
    last_step = job_end && (js_r || !s1_two_r);
    if (rs_r || (s1_row_r == RW'(1))) begin
      vres = sbblur_pkg::tap2(ent.newer, hsel);
    end else begin
      vres = sbblur_pkg::tap3(ent.older, ent.newer, hsel);
    end
    res_row      = rs_r ? s1_row_r : s1_row_r - RW'(1);
    wr_ent.older = ent.newer;
    wr_ent.newer = hsel;
    col_x        = COL_XW'(job_col);
    row_x        = ROW_XW'(res_row);
  end

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || (adv && last_step);

  // step through the jobs and results of the held pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      js_r       <= 1'b0;
      rs_r       <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
      js_r       <= 1'b0;
      rs_r       <= 1'b0;
    end else if (adv) begin
      if (job_end) begin
        rs_r <= 1'b0;
        if (last_step) begin
          s1_valid_r <= 1'b0;
          js_r       <= 1'b0;
        end else begin
          js_r <= 1'b1;
        end
      end else begin
        rs_r <= 1'b1;
      end
    end
  end

  // hold the payload of the pixel in the result stage
  always_ff @(posedge clk) begin
    if (load) begin
      s1_two_r      <= last_col;
      s1_last_row_r <= last_row;
      s1_row_r      <= row_r;
      s1_col_r      <= rd_addr_a;
      s1_h1_r       <= h1;
      s1_h2_r       <= h2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_pix_r  <= vres;
      out_col_r  <= col_x[sbblur_pkg::POS_W-1:0];
      out_row_r  <= row_x[sbblur_pkg::POS_W-1:0];
      out_last_r <= last_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_row_r, out_col_r, out_pix_r};
  assign out_tlast  = out_last_r;

  // second result of a job only in the last row
  a_second_res_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && rs_r |-> s1_last_row_r)
    else $error("second vertical result outside the last row");

  // second job only for a pixel that closed its row
  a_second_job_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && js_r |-> s1_two_r)
    else $error("second vertical job for a pixel inside the row");

  // a pixel past column 0 always enters the result stage
  a_load_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (col_r != '0) |=> s1_valid_r && !js_r && !rs_r)
    else $error("accepted pixel did not enter the result stage");

  // a row end wraps the column counter
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_col |=> col_r == '0)
    else $error("column counter did not wrap at row end");

endmodule
